// ----- rtl/core/nto_pkg.sv -----
// nto_pkg: shared types and constants for the node table core
// used by nto_table, nto_cmp and node_table_oldest_replace_core
package nto_pkg;

  localparam int ENTRIES_DEF = 64;
  localparam int WORD_W      = 64;
  localparam int KEY_W       = 256;
  localparam int ADDR_W      = 128;
  localparam int VER_W       = 32;
  localparam int REQ_W       = 2;

  localparam logic [REQ_W-1:0] REQ_DISCOVER = 2'd0;
  localparam logic [REQ_W-1:0] REQ_FORGET   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_GET      = 2'd2;

  // key = {w3, w2, w1, w0}, addr = {hi, lo}
  typedef struct packed {
    logic [WORD_W-1:0] seen;
    logic [KEY_W-1:0]  key;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] path;
    logic [VER_W-1:0]  ver;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic key_eq;
    logic addr_eq;
    logic live;
    logic older;
  } cmp_t;

  typedef struct packed {
    logic we;
    logic re;
  } mem_ctl_t;

endpackage

// ----- rtl/core/node_table_oldest_replace_core.sv -----
// node_table_oldest_replace_core: top level, request sequencer and result register
// depends on nto_pkg, nto_table and nto_cmp
//
// A request is taken when start is high and busy is low. Every request walks the
// table one entry per cycle through the single read port of the entry memory and
// one shared compare unit, so busy stays high for the whole scan;
// a discover or get that hits leaves the scan early, and an unknown request code
// answers without a scan. The answer is on the out_ ports for exactly one cycle,
// marked by out_valid, in the cycle before busy falls; the receiver cannot stall
// it. After reset a clearing pass zeroes the memory, one entry per cycle, and holds
// busy high until it is done.
module node_table_oldest_replace_core #(
  parameter int ENTRIES = nto_pkg::ENTRIES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [nto_pkg::REQ_W-1:0]     in_req_type,
  input  logic [nto_pkg::WORD_W-1:0]    in_key_w0,
  input  logic [nto_pkg::WORD_W-1:0]    in_key_w1,
  input  logic [nto_pkg::WORD_W-1:0]    in_key_w2,
  input  logic [nto_pkg::WORD_W-1:0]    in_key_w3,
  input  logic [nto_pkg::WORD_W-1:0]    in_addr_hi,
  input  logic [nto_pkg::WORD_W-1:0]    in_addr_lo,
  input  logic [nto_pkg::WORD_W-1:0]    in_route_path,
  input  logic [nto_pkg::VER_W-1:0]     in_proto_version,
  input  logic [nto_pkg::WORD_W-1:0]    in_now_ms,
  output logic                          out_valid,
  output logic                          out_found,
  output logic [nto_pkg::WORD_W-1:0]    out_key_w0,
  output logic [nto_pkg::WORD_W-1:0]    out_key_w1,
  output logic [nto_pkg::WORD_W-1:0]    out_key_w2,
  output logic [nto_pkg::WORD_W-1:0]    out_key_w3,
  output logic [nto_pkg::WORD_W-1:0]    out_addr_hi,
  output logic [nto_pkg::WORD_W-1:0]    out_addr_lo,
  output logic [nto_pkg::WORD_W-1:0]    out_path,
  output logic [nto_pkg::VER_W-1:0]     out_version
);
  import nto_pkg::*;

  localparam int IW    = $clog2(ENTRIES);
  localparam int CNT_W = IW + 1;

  localparam logic [1:0] S_CLR  = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [IW-1:0]     chk_r, chk_nxt;
  logic              rv_r, rv_nxt;
  logic              found_r, found_nxt;
  logic              vwr_r, vwr_nxt;
  logic [IW-1:0]     vidx_r, vidx_nxt;
  logic [WORD_W-1:0] vtime_r, vtime_nxt;
  entry_t            res_r, res_nxt;
  logic [REQ_W-1:0]  req_r, req_nxt;
  entry_t            rq_r, rq_nxt;

  mem_ctl_t          mctl;
  logic [IW-1:0]     wr_addr;
  entry_t            wr_data;
  entry_t            rd_data;
  cmp_t              cmp;
  logic              last;

  nto_table #(.ENTRIES(ENTRIES)) u_table (
    .clk     (clk),
    .ctl     (mctl),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (cnt_r[IW-1:0]),
    .rd_data (rd_data)
  );

  nto_cmp u_cmp (
    .ent   (rd_data),
    .key   (rq_r.key),
    .addr  (rq_r.addr),
    .vtime (vtime_r),
    .res   (cmp)
  );

  assign last = (chk_r == IW'(ENTRIES - 1));

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    chk_nxt   = chk_r;
    rv_nxt    = rv_r;
    found_nxt = found_r;
    vwr_nxt   = vwr_r;
    vidx_nxt  = vidx_r;
    vtime_nxt = vtime_r;
    res_nxt   = res_r;
    req_nxt   = req_r;
    rq_nxt    = rq_r;
    mctl      = '0;
    wr_addr   = chk_r;
    wr_data   = rd_data;

    unique case (state_r)
      S_CLR: begin
        mctl.we = 1'b1;
        wr_addr = cnt_r[IW-1:0];
        wr_data = '0;
        if (cnt_r == CNT_W'(ENTRIES - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (start) begin
          req_nxt      = in_req_type;
          rq_nxt.seen  = in_now_ms;
          rq_nxt.key   = {in_key_w3, in_key_w2, in_key_w1, in_key_w0};
          rq_nxt.addr  = {in_addr_hi, in_addr_lo};
          rq_nxt.path  = in_route_path;
          rq_nxt.ver   = in_proto_version;
          cnt_nxt      = '0;
          rv_nxt       = 1'b0;
          found_nxt    = 1'b0;
          vwr_nxt      = 1'b0;
          res_nxt      = '0;
          if (in_req_type == REQ_DISCOVER || in_req_type == REQ_FORGET ||
              in_req_type == REQ_GET) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (cnt_r < CNT_W'(ENTRIES)) begin
          mctl.re = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
          chk_nxt = cnt_r[IW-1:0];
          rv_nxt  = 1'b1;
        end else begin
          rv_nxt = 1'b0;
        end
        if (rv_r) begin
          case (req_r)
            REQ_DISCOVER: begin
              if (cmp.live && cmp.key_eq) begin
                mctl.we      = 1'b1;
                wr_data.path = rq_r.path;
                wr_data.seen = rq_r.seen;
                found_nxt    = 1'b1;
                res_nxt      = wr_data;
                state_nxt    = S_DONE;
              end else begin
                if (chk_r == '0 || cmp.older) begin
                  vidx_nxt  = chk_r;
                  vtime_nxt = rd_data.seen;
                end
                if (last) begin
                  vwr_nxt   = 1'b1;
                  state_nxt = S_DONE;
                end
              end
            end
            REQ_FORGET: begin
              if (cmp.key_eq) begin
                mctl.we      = 1'b1;
                wr_data.seen = '0;
                found_nxt    = 1'b1;
              end
              if (last) begin
                state_nxt = S_DONE;
              end
            end
            REQ_GET: begin
              if (cmp.addr_eq) begin
                found_nxt = 1'b1;
                res_nxt   = rd_data;
                state_nxt = S_DONE;
              end else if (last) begin
                state_nxt = S_DONE;
              end
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_DONE: begin
        if (vwr_r) begin
          mctl.we = 1'b1;
          wr_addr = vidx_r;
          wr_data = rq_r;
        end
        vwr_nxt   = 1'b0;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      cnt_r   <= '0;
      rv_r    <= 1'b0;
      vwr_r   <= 1'b0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      rv_r    <= rv_nxt;
      vwr_r   <= vwr_nxt;
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_r   <= chk_nxt;
    vidx_r  <= vidx_nxt;
    vtime_r <= vtime_nxt;
    res_r   <= res_nxt;
    req_r   <= req_nxt;
    rq_r    <= rq_nxt;
  end

  assign busy        = (state_r != S_IDLE);
  assign out_valid   = (state_r == S_DONE);
  assign out_found   = found_r;
  assign out_key_w0  = res_r.key[WORD_W-1:0];
  assign out_key_w1  = res_r.key[2*WORD_W-1:WORD_W];
  assign out_key_w2  = res_r.key[3*WORD_W-1:2*WORD_W];
  assign out_key_w3  = res_r.key[4*WORD_W-1:3*WORD_W];
  assign out_addr_hi = res_r.addr[2*WORD_W-1:WORD_W];
  assign out_addr_lo = res_r.addr[WORD_W-1:0];
  assign out_path    = res_r.path;
  assign out_version = res_r.ver;

  a_word_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result word outside busy window");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !mctl.we)
    else $error("table written while idle");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_found) |-> (out_key_w0 == '0 && out_addr_lo == '0 &&
                                   out_path == '0 && out_version == '0))
    else $error("miss word carries entry data");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

endmodule

// ----- rtl/core/nto_table.sv -----
// nto_table: entry storage, one write port and one registered read port
// depends on nto_pkg
module nto_table #(
  parameter int ENTRIES = nto_pkg::ENTRIES_DEF
) (
  input  logic                         clk,
  input  nto_pkg::mem_ctl_t            ctl,
  input  logic [$clog2(ENTRIES)-1:0]   wr_addr,
  input  nto_pkg::entry_t              wr_data,
  input  logic [$clog2(ENTRIES)-1:0]   rd_addr,
  output nto_pkg::entry_t              rd_data
);
  import nto_pkg::*;

  entry_t mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (ctl.we) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.re) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/nto_cmp.sv -----
// nto_cmp: shared compare unit applied to one table entry per cycle
// depends on nto_pkg
module nto_cmp (
  input  nto_pkg::entry_t              ent,
  input  logic [nto_pkg::KEY_W-1:0]    key,
  input  logic [nto_pkg::ADDR_W-1:0]   addr,
  input  logic [nto_pkg::WORD_W-1:0]   vtime,
  output nto_pkg::cmp_t                res
);
  import nto_pkg::*;

  always_comb begin
    res.key_eq  = (ent.key == key);
    res.addr_eq = (ent.addr == addr);
    res.live    = (ent.seen != '0);
    res.older   = (ent.seen < vtime);
  end

endmodule
